/* hw/rtl/sratoa_pkg.sv */
// Shared types and constants for the signed radix to text converter.
package sratoa_pkg;

	localparam int VALUE_W    = 64;
	localparam int CHAR_W     = 8;
	localparam int COUNT_W    = 7;
	localparam int RADIX_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int N_CHARS    = 16;
	localparam int CHAR_IDX_W = 4;

	localparam logic [CHAR_W-1:0] CHAR_MIN   = 8'd32;
	localparam logic [CHAR_W-1:0] CHAR_MAX   = 8'd126;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	localparam logic [RADIX_W-1:0]    RST_RADIX_LEN  = 5'd10;
	localparam logic [CFG_DATA_W-1:0] RST_CHARS_LOW  = 64'h3736353433323130;
	localparam logic [CFG_DATA_W-1:0] RST_CHARS_HIGH = 64'h6665646362613938;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIX_LEN  = 2'd0,
		REG_CHARS_LOW  = 2'd1,
		REG_CHARS_HIGH = 2'd2
	} reg_idx_t;

	typedef logic [CHAR_W-1:0] char_t;

	typedef struct packed {
		logic push;
		logic last;
	} div_ev_t;

	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		logic               ok;
	} cfg_st_t;

endpackage

/* hw/rtl/sratoa_if.sv */
// Handshake channel interfaces for the converter input and output items.
interface sratoa_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [sratoa_pkg::VALUE_W-1:0]   value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface sratoa_out_if;
	logic                               valid;
	logic                               ready;
	logic [sratoa_pkg::CHAR_W-1:0]      digit_char;
	logic                               minus_first;
	logic                               last_digit;
	logic [sratoa_pkg::COUNT_W-1:0]     char_count;

	modport source (output valid, output digit_char, output minus_first,
		output last_digit, output char_count, input ready);
	modport sink (input valid, input digit_char, input minus_first,
		input last_digit, input char_count, output ready);
endinterface

/* hw/rtl/signed_radix_to_ascii.sv */
// Top level of the signed radix to text converter.
//
//   port     | dir  | carries
//   ---------+------+--------------------------------------------------
//   num      | in   | value, a signed integer to convert
//   text     | out  | digit_char, minus_first, last_digit, char_count
//   cfg_*    | in   | writes of radix_length and the digit table
//
// One item is handled at a time; num.ready is high only when the block is idle.
// An item passes a table check, then an align step that skips leading zero nibbles,
// then for each digit a pass over the significant nibbles of the current quotient,
// with the divider consuming four dividend bits per cycle, and then the digits are sent.
// Reset is asynchronous and restores the default decimal table.
// A stalled text output holds its item; nothing else moves until it is taken.
module signed_radix_to_ascii import sratoa_pkg::*; #(
	parameter int MAX_RADIX  = 16,
	parameter int VALUE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sratoa_in_if.sink             num,
	sratoa_out_if.source          text
);

	localparam int DW = $clog2(MAX_RADIX);
	localparam int CW = $clog2(VALUE_BITS + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_CONV  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [VALUE_BITS-1:0]  mag_q;
	logic                   neg_q;
	logic [CW-1:0]          n_q;
	logic [CW-1:0]          left_q;
	logic                   first_q;

	cfg_st_t                cfg_st;
	char_t                  chars [N_CHARS];
	div_ev_t                div_ev;
	logic [DW-1:0]          div_digit;
	logic [DW-1:0]          stk_top;
	logic                   div_start;
	logic                   pop;
	logic                   in_acc;
	logic [VALUE_BITS-1:0]  x;

	assign x         = num.value[VALUE_BITS-1:0];
	assign num.ready = (state_q == ST_IDLE);
	assign in_acc    = num.valid && num.ready;
	assign div_start = (state_q == ST_CHECK) && cfg_st.ok;
	assign pop       = text.valid && text.ready;

	sratoa_cfg #(
		.MAX_RADIX (MAX_RADIX)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_index),
		.data   (cfg_data),
		.st     (cfg_st),
		.chars  (chars)
	);

	sratoa_div #(
		.VALUE_BITS (VALUE_BITS),
		.DW         (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (mag_q),
		.radix  (cfg_st.radix),
		.ev     (div_ev),
		.digit  (div_digit)
	);

	sratoa_stack #(
		.DEPTH (VALUE_BITS),
		.DW    (DW)
	) u_stack (
		.clk  (clk),
		.push (div_ev.push),
		.pop  (pop),
		.din  (div_digit),
		.top  (stk_top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			left_q  <= '0;
			first_q <= 1'b0;
			neg_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						neg_q   <= x[VALUE_BITS-1];
						n_q     <= '0;
						left_q  <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= cfg_st.ok ? ST_CONV : ST_IDLE;
				end
				ST_CONV: begin
					if (div_ev.push) begin
						n_q    <= n_q + CW'(1);
						left_q <= left_q + CW'(1);
						if (div_ev.last) begin
							first_q <= 1'b1;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (pop) begin
						first_q <= 1'b0;
						left_q  <= left_q - CW'(1);
						if (left_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_q <= x[VALUE_BITS-1] ? (~x + VALUE_BITS'(1)) : x;
		end
	end

	assign text.valid       = (state_q == ST_EMIT);
	assign text.digit_char  = chars[CHAR_IDX_W'(stk_top)];
	assign text.minus_first = first_q && neg_q;
	assign text.last_digit  = (left_q == CW'(1));
	assign text.char_count  = (left_q == CW'(1)) ?
		(COUNT_W'(n_q) + COUNT_W'(neg_q)) : '0;

endmodule

/* hw/rtl/sratoa_cfg.sv */
// Configuration registers and digit table validity check.
module sratoa_cfg import sratoa_pkg::*; #(
	parameter int MAX_RADIX = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_IDX_W-1:0]  idx,
	input  logic [CFG_DATA_W-1:0] data,
	output cfg_st_t               st,
	output char_t                 chars [N_CHARS]
);

	logic [RADIX_W-1:0]    radix_len_q;
	logic [CFG_DATA_W-1:0] chars_low_q;
	logic [CFG_DATA_W-1:0] chars_high_q;
	logic                  ok_q;
	logic                  ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_len_q  <= RST_RADIX_LEN;
			chars_low_q  <= RST_CHARS_LOW;
			chars_high_q <= RST_CHARS_HIGH;
		end else if (we) begin
			unique case (reg_idx_t'(idx))
				REG_RADIX_LEN:  radix_len_q  <= data[RADIX_W-1:0];
				REG_CHARS_LOW:  chars_low_q  <= data;
				REG_CHARS_HIGH: chars_high_q <= data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < N_CHARS / 2; i++) begin
			chars[i]               = chars_low_q[i*CHAR_W +: CHAR_W];
			chars[i + N_CHARS / 2] = chars_high_q[i*CHAR_W +: CHAR_W];
		end
	end

	always_comb begin
		ok = (radix_len_q >= RADIX_W'(2)) && (radix_len_q <= RADIX_W'(MAX_RADIX));
		for (int i = 0; i < N_CHARS; i++) begin
			if (RADIX_W'(i) < radix_len_q) begin
				if (chars[i] < CHAR_MIN || chars[i] > CHAR_MAX ||
						chars[i] == CHAR_PLUS || chars[i] == CHAR_MINUS) begin
					ok = 1'b0;
				end
				for (int j = i + 1; j < N_CHARS; j++) begin
					if (RADIX_W'(j) < radix_len_q && chars[j] == chars[i]) begin
						ok = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else begin
			ok_q <= ok;
		end
	end

	assign st.radix = radix_len_q;
	assign st.ok    = ok_q;

endmodule

/* hw/rtl/sratoa_div.sv */
// Nibble-serial divider that peels off one digit per pass over the magnitude.
module sratoa_div import sratoa_pkg::*; #(
	parameter int VALUE_BITS = 64,
	parameter int DW         = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] mag,
	input  logic [RADIX_W-1:0]    radix,
	output div_ev_t               ev,
	output logic [DW-1:0]         digit
);

	localparam int NW = (VALUE_BITS + 3) / 4;
	localparam int SW = NW * 4;
	localparam int WW = $clog2(NW + 1);

	typedef enum logic [2:0] {
		D_IDLE  = 3'b001,
		D_ALIGN = 3'b010,
		D_DIV   = 3'b100
	} dstate_t;

	dstate_t        state_q;
	logic [SW-1:0]  sh_q;
	logic [WW-1:0]  win_q;
	logic [WW-1:0]  pos_q;
	logic [DW-1:0]  rem_q;
	logic           drop_q;
	logic           nz_q;

	logic [3:0]     top_nib;
	logic [3:0]     q;
	logic [DW-1:0]  r;
	logic           first;
	logic           drop_now;
	logic           drop;
	logic           append;
	logic           last_pos;
	logic           nz_new;
	logic [WW-1:0]  ins;
	logic [SW-1:0]  sh_nxt;

	assign top_nib = sh_q[SW-1 -: 4];

	always_comb begin
		logic [DW:0]        t;
		logic [RADIX_W-1:0] diff;
		diff = '0;
		r = rem_q;
		q = 4'd0;
		for (int b = 3; b >= 0; b--) begin
			t = {r, top_nib[b]};
			if (RADIX_W'(t) >= radix) begin
				q[b] = 1'b1;
				diff = RADIX_W'(t) - radix;
				r    = diff[DW-1:0];
			end else begin
				r = t[DW-1:0];
			end
		end
	end

	assign first    = (pos_q == '0);
	assign drop_now = first && (q == 4'd0) && (win_q != WW'(1));
	assign drop     = first ? drop_now : drop_q;
	assign append   = !(first && drop_now);
	assign ins      = win_q - WW'(1) - WW'(drop_q && !first);
	assign last_pos = (pos_q == win_q - WW'(1));
	assign nz_new   = first ? (q != 4'd0) : (nz_q || (q != 4'd0));

	always_comb begin
		sh_nxt = sh_q << 4;
		for (int i = 0; i < NW; i++) begin
			if (append && ins == WW'(i)) begin
				sh_nxt[(NW-1-i)*4 +: 4] = q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			win_q   <= '0;
			pos_q   <= '0;
			drop_q  <= 1'b0;
			nz_q    <= 1'b0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						win_q   <= WW'(NW);
						state_q <= D_ALIGN;
					end
				end
				D_ALIGN: begin
					if (top_nib == 4'd0 && win_q != WW'(1)) begin
						win_q <= win_q - WW'(1);
					end else begin
						pos_q   <= '0;
						state_q <= D_DIV;
					end
				end
				D_DIV: begin
					if (first) begin
						drop_q <= drop_now;
					end
					nz_q <= nz_new;
					if (last_pos) begin
						pos_q <= '0;
						win_q <= win_q - WW'(drop);
						if (!nz_new) begin
							state_q <= D_IDLE;
						end
					end else begin
						pos_q <= pos_q + WW'(1);
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				sh_q  <= SW'(mag);
				rem_q <= '0;
			end
			D_ALIGN: begin
				if (top_nib == 4'd0 && win_q != WW'(1)) begin
					sh_q <= sh_q << 4;
				end
				rem_q <= '0;
			end
			D_DIV: begin
				sh_q  <= sh_nxt;
				rem_q <= last_pos ? '0 : r;
			end
			default: rem_q <= '0;
		endcase
	end

	assign ev.push = (state_q == D_DIV) && last_pos;
	assign ev.last = ev.push && !nz_new;
	assign digit   = r;

endmodule

/* hw/rtl/sratoa_stack.sv */
// Digit stack that reverses the divider's least-significant-first order.
module sratoa_stack #(
	parameter int DEPTH = 64,
	parameter int DW    = 4
) (
	input  logic          clk,
	input  logic          push,
	input  logic          pop,
	input  logic [DW-1:0] din,
	output logic [DW-1:0] top
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				mem_q[i] <= mem_q[i-1];
			end
		end else if (pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				mem_q[i] <= mem_q[i+1];
			end
		end
	end

	assign top = mem_q[0];

endmodule

/* hw/rtl/sratoa_chk.sv */
// Port-level assertions for the converter, bound to its top level.
module sratoa_chk import sratoa_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [CHAR_W-1:0]  digit_char,
	input logic               minus_first,
	input logic               last_digit,
	input logic [COUNT_W-1:0] char_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digit_char) &&
		$stable(minus_first) && $stable(last_digit) && $stable(char_count))
		else $error("Stalled output item changed.");

	a_count_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_digit |-> char_count == '0)
		else $error("Character count shown before the last digit.");

	a_count_minus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && minus_first && last_digit |-> char_count == COUNT_W'(2))
		else $error("Single-digit negative value has a wrong count.");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !out_valid)
		else $error("Input taken again or output shown right after an item.");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("Input ready while digits are still being sent.");

endmodule

bind signed_radix_to_ascii sratoa_chk u_sratoa_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (num.valid),
	.in_ready    (num.ready),
	.out_valid   (text.valid),
	.out_ready   (text.ready),
	.digit_char  (text.digit_char),
	.minus_first (text.minus_first),
	.last_digit  (text.last_digit),
	.char_count  (text.char_count)
);

/* sim/sratoa_checker.sv */
// Checker for the signed radix to text converter: predicts digit items and compares them.
`timescale 1ns / 100ps

module sratoa_checker import sratoa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sratoa_in_if                  num,
	sratoa_out_if                 text,
	output int                    fails,
	output int                    pending
);

	typedef struct packed {
		char_t              digit_char;
		logic               minus_first;
		logic               last_digit;
		logic [COUNT_W-1:0] char_count;
	} text_item_t;

	logic [RADIX_W-1:0]    radix_len;
	logic [CFG_DATA_W-1:0] chars_lo;
	logic [CFG_DATA_W-1:0] chars_hi;
	text_item_t            digits_due[$];
	int                    errs = 0;

	function automatic char_t table_char(int k);
		logic [CFG_DATA_W-1:0] word;
		word = (k >= 8) ? chars_hi : chars_lo;
		return word[(k % 8) * CHAR_W +: CHAR_W];
	endfunction

	function automatic bit table_ok();
		char_t c;
		if (radix_len < 2 || radix_len > N_CHARS)
			return 1'b0;
		for (int i = 0; i < radix_len; i++) begin
			c = table_char(i);
			if (c < CHAR_MIN || c > CHAR_MAX || c == CHAR_PLUS || c == CHAR_MINUS)
				return 1'b0;
			for (int j = i + 1; j < radix_len; j++)
				if (table_char(j) == c)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// Queues one item per digit, most significant first, or nothing when the table is invalid.
	function automatic void predict_text(logic [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] mag;
		logic               neg;
		int                 dg[VALUE_W];
		int                 n;
		text_item_t         t;
		if (!table_ok())
			return;
		neg = v[VALUE_W-1];
		mag = neg ? (~v + 1'b1) : v;
		n = 0;
		do begin
			dg[n] = int'(mag % radix_len);
			mag = mag / radix_len;
			n++;
		end while (mag != 0 && n < VALUE_W);
		for (int k = 0; k < n; k++) begin
			t.digit_char  = table_char(dg[n - 1 - k]);
			t.minus_first = (k == 0) && neg;
			t.last_digit  = (k == n - 1);
			t.char_count  = t.last_digit ? COUNT_W'(n + int'(neg)) : '0;
			digits_due.push_back(t);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		text_item_t t;
		if (!arst_n) begin
			radix_len = RST_RADIX_LEN;
			chars_lo  = RST_CHARS_LOW;
			chars_hi  = RST_CHARS_HIGH;
			digits_due.delete();
			pending <= 0;
			fails   <= errs;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RADIX_LEN:  radix_len = cfg_data[RADIX_W-1:0];
					REG_CHARS_LOW:  chars_lo  = cfg_data;
					REG_CHARS_HIGH: chars_hi  = cfg_data;
					default: ;
				endcase
			end
			if (num.valid && num.ready)
				predict_text(num.value);
			if (text.valid && text.ready) begin
				if (digits_due.size() == 0) begin
					$error("unexpected text item: digit_char %h", text.digit_char);
					errs++;
				end else begin
					t = digits_due.pop_front();
					if (text.digit_char !== t.digit_char) begin
						$error("digit_char: expected %h, got %h", t.digit_char, text.digit_char);
						errs++;
					end
					if (text.minus_first !== t.minus_first) begin
						$error("minus_first: expected %b, got %b", t.minus_first,
							text.minus_first);
						errs++;
					end
					if (text.last_digit !== t.last_digit) begin
						$error("last_digit: expected %b, got %b", t.last_digit, text.last_digit);
						errs++;
					end
					if (text.char_count !== t.char_count) begin
						$error("char_count: expected %0d, got %0d", t.char_count,
							text.char_count);
						errs++;
					end
				end
			end
			pending <= digits_due.size();
			fails   <= errs;
		end
	end

endmodule

/* sim/tb_top.sv */
// Testbench top for the signed radix to text converter: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_top import sratoa_pkg::*; ();

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int                   LIMIT      = 6000000;
	localparam int                   SETTLE     = 200;
	localparam int                   HOLD_OFF   = 400;
	localparam int                   PHASES     = 10;
	localparam int                   PHASE_LEN  = 25;
	localparam logic [VALUE_W-1:0]   VAL_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VALUE_W-1:0]   VAL_MIN    = 64'h8000_0000_0000_0000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fails;
	int                    pending;
	int                    cycles = 0;
	bit                    hold_req = 1'b0;
	bit                    idle_on = 1'b1;

	sratoa_in_if  num();
	sratoa_out_if text();

	signed_radix_to_ascii i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.num       (num),
		.text      (text)
	);

	sratoa_checker i_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.num       (num),
		.text      (text),
		.fails     (fails),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Mostly no gap, some short ones and a few long ones.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(40, 60);
	endfunction

	function automatic logic [VALUE_W-1:0] rand_value();
		logic [VALUE_W-1:0] v;
		int                 w;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: ;
			4: begin
				case ($urandom_range(0, 4))
					0: v = '0;
					1: v = VAL_MAX;
					2: v = VAL_MIN;
					3: v = '1;
					default: v = 64'd1;
				endcase
			end
			default: begin
				w = $urandom_range(1, VALUE_W - 1);
				v = v >> (VALUE_W - w);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	// Distinct printable digit characters in the first len entries, any bytes beyond.
	function automatic logic [2*CFG_DATA_W-1:0] make_table(int len);
		logic [2*CFG_DATA_W-1:0] tbl;
		bit                      used[256];
		char_t                   c;
		tbl = {$urandom, $urandom, $urandom, $urandom};
		for (int i = 0; i < len; i++) begin
			do
				c = char_t'($urandom_range(CHAR_MIN, CHAR_MAX));
			while (c == CHAR_PLUS || c == CHAR_MINUS || used[c]);
			used[c] = 1'b1;
			tbl[i * CHAR_W +: CHAR_W] = c;
		end
		return tbl;
	endfunction

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
	endtask

	task automatic set_table(logic [CFG_DATA_W-1:0] len_word, logic [CFG_DATA_W-1:0] lo,
		logic [CFG_DATA_W-1:0] hi);
		int r;
		r = $urandom_range(0, 2);
		for (int i = 0; i < 3; i++) begin
			case ((r + i) % 3)
				0: put_reg(REG_RADIX_LEN, len_word);
				1: put_reg(REG_CHARS_LOW, lo);
				default: put_reg(REG_CHARS_HIGH, hi);
			endcase
		end
		put_reg(REG_UNUSED, {$urandom, $urandom});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send(logic [VALUE_W-1:0] v);
		int g;
		g = idle_on ? gap_len() : 0;
		if (g > 0) begin
			num.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		num.valid <= 1'b1;
		num.value <= v;
		do
			@(posedge clk);
		while (!num.ready);
	endtask

	// Waits until every predicted digit has come out, then lets an item with no output finish.
	task automatic settle();
		num.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic try_config(logic [CFG_DATA_W-1:0] len_word, logic [CFG_DATA_W-1:0] lo,
		logic [CFG_DATA_W-1:0] hi, logic [VALUE_W-1:0] v);
		set_table(len_word, lo, hi);
		send(v);
		settle();
	endtask

	initial begin
		int r;
		text.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				text.ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else begin
				text.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
				r = idle_on ? gap_len() : 0;
				if (r > 0) begin
					text.ready <= 1'b0;
					repeat (r) @(posedge clk);
				end
			end
		end
	end

	initial begin
		logic [2*CFG_DATA_W-1:0] tbl;
		logic [CFG_DATA_W-1:0]   len_word;
		char_t                   c;
		int                      radix;
		int                      j;
		num.valid = 1'b0;
		num.value = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_RADIX_LEN;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Decimal table from reset.
		send('0);
		send('1);
		send(64'd12345);
		send(VAL_MAX);
		send(VAL_MIN);
		settle();

		// Binary with the lowest and highest printable characters; entries 2 to 7 are plus signs.
		set_table(64'd2, {{6{CHAR_PLUS}}, CHAR_MAX, CHAR_MIN}, RST_CHARS_HIGH);
		send(VAL_MIN);
		send(VAL_MAX);
		send('0);
		settle();

		// Radix 16 written with junk above the five length bits.
		set_table(64'hFFFF_FFFF_FFFF_FFF0, RST_CHARS_LOW, RST_CHARS_HIGH);
		send('1);
		send(VAL_MIN);
		settle();

		// Bad lengths and bad characters give no output; the last table is valid.
		try_config(64'd0, RST_CHARS_LOW, RST_CHARS_HIGH, 64'd12345);
		try_config(64'd1, RST_CHARS_LOW, RST_CHARS_HIGH, 64'd12345);
		try_config(64'd17, RST_CHARS_LOW, RST_CHARS_HIGH, 64'd12345);
		try_config(64'd31, RST_CHARS_LOW, RST_CHARS_HIGH, 64'd12345);
		try_config(64'd16, {RST_CHARS_LOW[63:48], CHAR_PLUS, RST_CHARS_LOW[39:0]},
			RST_CHARS_HIGH, '1);
		try_config(64'd16, {RST_CHARS_LOW[63:8], CHAR_MINUS}, RST_CHARS_HIGH, '1);
		try_config(64'd16, RST_CHARS_LOW, {CHAR_MIN - 8'd1, RST_CHARS_HIGH[55:0]}, '1);
		try_config(64'd16, RST_CHARS_LOW, {CHAR_MAX + 8'd1, RST_CHARS_HIGH[55:0]}, '1);
		try_config(64'd16, RST_CHARS_LOW, {RST_CHARS_LOW[7:0], RST_CHARS_HIGH[55:0]}, '1);
		try_config(64'd16, {RST_CHARS_LOW[63:8], CHAR_MIN}, {CHAR_MAX, RST_CHARS_HIGH[55:0]},
			VAL_MIN);

		for (int ph = 0; ph < PHASES; ph++) begin
			idle_on = (ph % 3 != 1);
			if (ph == 0)
				radix = 2;
			else if (ph == 1)
				radix = N_CHARS;
			else
				radix = $urandom_range(2, N_CHARS);
			tbl = make_table(radix);
			len_word = {$urandom, $urandom};
			len_word[RADIX_W-1:0] = RADIX_W'(radix);
			set_table(len_word, tbl[CFG_DATA_W-1:0], tbl[2*CFG_DATA_W-1:CFG_DATA_W]);
			// The output side stalls for a long stretch while items keep coming.
			if (ph == 4)
				hold_req = 1'b1;
			for (int i = 0; i < PHASE_LEN; i++)
				send(rand_value());
			settle();

			if (ph % 2 == 1) begin
				j = $urandom_range(0, radix - 1);
				case ($urandom_range(0, 4))
					0: c = CHAR_PLUS;
					1: c = CHAR_MINUS;
					2: c = char_t'($urandom_range(0, CHAR_MIN - 1));
					3: c = char_t'($urandom_range(CHAR_MAX + 1, 255));
					default: c = tbl[((j + 1) % radix) * CHAR_W +: CHAR_W];
				endcase
				tbl[j * CHAR_W +: CHAR_W] = c;
				set_table(len_word, tbl[CFG_DATA_W-1:0], tbl[2*CFG_DATA_W-1:CFG_DATA_W]);
				for (int i = 0; i < 3; i++)
					send(rand_value());
				settle();
			end
		end

		if (fails == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
